>>> rtl/core/per_client_sliding_window_limiter_assert.svh
// Assertion macros shared by the limiter's checker.
// Depends on signals named clk and rst_n in the scope of use.
`ifndef PER_CLIENT_SLIDING_WINDOW_LIMITER_ASSERT_SVH
`define PER_CLIENT_SLIDING_WINDOW_LIMITER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PCSWL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcswl: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define PCSWL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcswl: next-cycle check failed");

`endif

>>> rtl/core/pcswl_pkg.sv
// Package for the per-client sliding window limiter.
// Holds default sizes, the window reset value and controller/datapath structs.
package pcswl_pkg;

  localparam int TRACKED_CLIENTS_DEF     = 16;
  localparam int REQUESTS_PER_WINDOW_DEF = 64;
  localparam int ID_W                    = 32;
  localparam int STAMP_W                 = 32;

  localparam logic [STAMP_W-1:0] WINDOW_RESET = 32'd60000;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;       // latch request, restart table scan
    logic scan_step;   // examine one table entry
    logic select;      // pick and claim the slot
    logic load_base;   // fetch ring base, fill and write position
    logic count_step;  // issue one stamp read
    logic decide;      // admit or refuse, log stamp
  } pcswl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_last;   // current scan entry is the last one
    logic count_done;  // all logged stamps have been read
  } pcswl_sts_t;

endpackage

>>> rtl/core/pcswl_ctrl.sv
// Controller state machine for the per-client sliding window limiter.
// Depends on pcswl_pkg for the command and status structs.
module pcswl_ctrl import pcswl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  pcswl_sts_t sts,
  output pcswl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SELECT,
    ST_BASE,
    ST_COUNT,
    ST_DECIDE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // Result register can take a new value when empty or being drained
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_SELECT;
        end
      end
      ST_SELECT: begin
        cmd.select = 1'b1;
        state_nxt  = ST_BASE;
      end
      ST_BASE: begin
        cmd.load_base = 1'b1;
        state_nxt     = ST_COUNT;
      end
      ST_COUNT: begin
        if (sts.count_done) begin
          state_nxt = ST_DECIDE;
        end else begin
          cmd.count_step = 1'b1;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          cmd.decide    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/pcswl_datapath.sv
// Datapath of the per-client sliding window limiter: client table, stamp
// memory, window register and result register. Depends on pcswl_pkg.
module pcswl_datapath import pcswl_pkg::*; #(
  parameter int TRACKED_CLIENTS     = TRACKED_CLIENTS_DEF,
  parameter int REQUESTS_PER_WINDOW = REQUESTS_PER_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ID_W-1:0]    in_client_id,
  input  logic [STAMP_W-1:0] in_now_ms,
  input  logic               cfg_write,
  input  logic [STAMP_W-1:0] cfg_window_length_ms,
  input  pcswl_cmd_t         cmd,
  output pcswl_sts_t         sts,
  output logic               out_allowed
);

  localparam int SW        = (TRACKED_CLIENTS > 1) ? $clog2(TRACKED_CLIENTS) : 1;
  localparam int PW        = (REQUESTS_PER_WINDOW > 1) ? $clog2(REQUESTS_PER_WINDOW) : 1;
  localparam int FW        = $clog2(REQUESTS_PER_WINDOW + 1);
  localparam int MEM_DEPTH = TRACKED_CLIENTS * REQUESTS_PER_WINDOW;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Client table
  logic               entry_used_r   [TRACKED_CLIENTS];
  logic [ID_W-1:0]    entry_client_r [TRACKED_CLIENTS];
  logic [STAMP_W-1:0] entry_seen_r   [TRACKED_CLIENTS];
  logic [PW-1:0]      ring_pos_r     [TRACKED_CLIENTS];
  logic [FW-1:0]      ring_fill_r    [TRACKED_CLIENTS];

  // Stamp rings, one block of REQUESTS_PER_WINDOW words per client
  logic [STAMP_W-1:0] stamp_mem [MEM_DEPTH];

  logic [STAMP_W-1:0] window_r;
  logic [ID_W-1:0]    id_r;
  logic [STAMP_W-1:0] now_r;
  logic [SW-1:0]      scan_idx_r;
  logic               match_r;
  logic [SW-1:0]      match_idx_r;
  logic               free_r;
  logic [SW-1:0]      free_idx_r;
  logic [SW-1:0]      min_idx_r;
  logic [STAMP_W-1:0] min_val_r;
  logic [SW-1:0]      slot_r;
  logic [SW-1:0]      slot_nxt;
  logic [AW-1:0]      base_r;
  logic [FW-1:0]      fill_r;
  logic [PW-1:0]      pos_r;
  logic [FW-1:0]      k_r;
  logic [FW-1:0]      count_r;
  logic [FW-1:0]      count_nxt;
  logic               rd_pend_r;
  logic [STAMP_W-1:0] mem_q_r;
  logic               out_allowed_r;

  logic               cur_used;
  logic               cur_hit;
  logic               cur_older;
  logic               stamp_hit;
  logic               admit;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [PW-1:0]      pos_adv;
  logic [FW-1:0]      fill_adv;

  // Examine the entry under the scan index
  assign cur_used  = entry_used_r[scan_idx_r];
  assign cur_hit   = cur_used && (entry_client_r[scan_idx_r] == id_r);
  assign cur_older = (scan_idx_r == '0) || (entry_seen_r[scan_idx_r] < min_val_r);

  // Hit first, then lowest free entry, then the least recently seen
  assign slot_nxt = match_r ? match_idx_r : (free_r ? free_idx_r : min_idx_r);

  // A stamp counts when not in the future and inside the window
  assign stamp_hit = rd_pend_r && (mem_q_r <= now_r) && ((now_r - mem_q_r) < window_r);
  assign count_nxt = count_r + FW'(stamp_hit);
  assign admit     = (count_r < FW'(REQUESTS_PER_WINDOW));

  assign rd_addr  = base_r + AW'(k_r);
  assign wr_addr  = base_r + AW'(pos_r);
  assign pos_adv  = (pos_r == PW'(REQUESTS_PER_WINDOW - 1)) ? '0 : pos_r + 1'b1;
  assign fill_adv = (fill_r == FW'(REQUESTS_PER_WINDOW)) ? fill_r : fill_r + 1'b1;

  assign sts.scan_last  = (scan_idx_r == SW'(TRACKED_CLIENTS - 1));
  assign sts.count_done = (k_r == fill_r);
  assign out_allowed    = out_allowed_r;

  // Control state: used bits, ring pointers, window, read pending
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TRACKED_CLIENTS; i++) begin
        entry_used_r[i] <= 1'b0;
        ring_pos_r[i]   <= '0;
        ring_fill_r[i]  <= '0;
      end
      window_r  <= WINDOW_RESET;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.count_step;
      if (cfg_write) begin
        window_r <= cfg_window_length_ms;
      end
      // Claim the slot and clear its ring on allocation
      if (cmd.select && !match_r) begin
        entry_used_r[slot_nxt] <= 1'b1;
        ring_pos_r[slot_nxt]   <= '0;
        ring_fill_r[slot_nxt]  <= '0;
      end
      // Advance the ring after an admitted request
      if (cmd.decide && admit) begin
        ring_pos_r[slot_r]  <= pos_adv;
        ring_fill_r[slot_r] <= fill_adv;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      id_r       <= in_client_id;
      now_r      <= in_now_ms;
      scan_idx_r <= '0;
      match_r    <= 1'b0;
      free_r     <= 1'b0;
    end
    if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (cur_hit && !match_r) begin
        match_r     <= 1'b1;
        match_idx_r <= scan_idx_r;
      end
      if (!cur_used && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= scan_idx_r;
      end
      if (cur_older) begin
        min_idx_r <= scan_idx_r;
        min_val_r <= entry_seen_r[scan_idx_r];
      end
    end
    if (cmd.select) begin
      slot_r                 <= slot_nxt;
      entry_seen_r[slot_nxt] <= now_r;
      if (!match_r) begin
        entry_client_r[slot_nxt] <= id_r;
      end
    end
    if (cmd.load_base) begin
      base_r  <= AW'(slot_r * REQUESTS_PER_WINDOW);
      fill_r  <= ring_fill_r[slot_r];
      pos_r   <= ring_pos_r[slot_r];
      k_r     <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    if (cmd.count_step) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.decide) begin
      out_allowed_r <= admit;
    end
  end

  // Stamp memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.decide && admit) begin
      stamp_mem[wr_addr] <= now_r;
    end
    if (cmd.count_step) begin
      mem_q_r <= stamp_mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/per_client_sliding_window_limiter.sv
// Top level of the per-client sliding window limiter.
// Depends on pcswl_pkg, pcswl_ctrl and pcswl_datapath.
//
//   channel | ports                                   | role
//   --------+-----------------------------------------+--------------------------
//   in      | in_valid in_ready in_client_id in_now_ms | one request per transaction
//   out     | out_valid out_ready out_allowed          | one verdict per request
//   cfg     | cfg_valid cfg_ready cfg_window_length_ms | window length write
//
// From acceptance to a loaded verdict, a request scans the client table one
// entry at a time, claims a slot, loads its ring and reads the logged stamps
// one at a time through the single read port of the stamp memory.
// Synchronous active-low reset clears the used bits and ring pointers and sets
// the window to 60000 ms; no clearing pass. A stalled verdict holds in the output
// register while the next request is accepted; that request then waits
// before loading its own verdict. cfg_ready is always high.
module per_client_sliding_window_limiter import pcswl_pkg::*; #(
  parameter int TRACKED_CLIENTS     = TRACKED_CLIENTS_DEF,
  parameter int REQUESTS_PER_WINDOW = REQUESTS_PER_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ID_W-1:0]    in_client_id,
  input  logic [STAMP_W-1:0] in_now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_allowed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [STAMP_W-1:0] cfg_window_length_ms
);

  pcswl_cmd_t cmd;
  pcswl_sts_t sts;

  // Register writes are taken at any time
  assign cfg_ready = 1'b1;

  pcswl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcswl_datapath #(
    .TRACKED_CLIENTS     (TRACKED_CLIENTS),
    .REQUESTS_PER_WINDOW (REQUESTS_PER_WINDOW)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_client_id         (in_client_id),
    .in_now_ms            (in_now_ms),
    .cfg_write            (cfg_valid && cfg_ready),
    .cfg_window_length_ms (cfg_window_length_ms),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_allowed          (out_allowed)
  );

endmodule

>>> rtl/core/pcswl_checker.sv
// Port-level checker for the per-client sliding window limiter, bound to
// the top level. Depends on per_client_sliding_window_limiter_assert.svh.
`include "per_client_sliding_window_limiter_assert.svh"

module pcswl_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_allowed
);

  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track requests accepted but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  `PCSWL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `PCSWL_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_allowed))
  `PCSWL_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready)
  `PCSWL_ASSERT_SAME(a_no_invented_result, out_valid, pend_r != 2'd0)

endmodule

bind per_client_sliding_window_limiter pcswl_checker u_pcswl_checker (.*);
